>>> design/vfc_pkg.sv
// ============================================================================
// vfc_pkg: shared types and constants of the voxel face culling core
// Cell type codes, operation codes, face directions, word layouts and the
// default chunk dimensions.
// ============================================================================
`default_nettype none

package vfc_pkg;

    // Default interior size of one chunk
    localparam int X_LEN_DEF = 16;
    localparam int Y_LEN_DEF = 16;
    localparam int Z_LEN_DEF = 16;

    // Widths fixed by the word layouts
    localparam int POS_W  = 5;
    localparam int CELL_W = 2;
    localparam int CODE_W = 17;
    localparam int DIR_W  = 3;
    localparam int NUM_DIRS = 6;

    // Cell types
    localparam logic [CELL_W-1:0] CELL_AIR   = 2'd0;
    localparam logic [CELL_W-1:0] CELL_WATER = 2'd1;
    localparam logic [CELL_W-1:0] CELL_SOLID = 2'd2;
    localparam logic [CELL_W-1:0] CELL_ALT   = 2'd3;

    // Operations
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Face directions, in emission order
    localparam logic [DIR_W-1:0] DIR_UP     = 3'd0;
    localparam logic [DIR_W-1:0] DIR_BOTTOM = 3'd1;
    localparam logic [DIR_W-1:0] DIR_FRONT  = 3'd2;
    localparam logic [DIR_W-1:0] DIR_BACK   = 3'd3;
    localparam logic [DIR_W-1:0] DIR_LEFT   = 3'd4;
    localparam logic [DIR_W-1:0] DIR_RIGHT  = 3'd5;

    typedef struct packed {
        logic              op;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [POS_W-1:0]  pos_z;
        logic [CELL_W-1:0] cell_type;
    } cmd_word_t;

    typedef struct packed {
        logic [CODE_W-1:0] face_code;
        logic [DIR_W-1:0]  face_dir;
        logic              transparent;
        logic              face_present;
        logic              query_error;
        logic              last;
    } face_word_t;

endpackage

`default_nettype wire

>>> design/vfc_if.sv
// ============================================================================
// vfc_if: valid/ready channels of the voxel face culling core
// One channel for command words, one for face words.
// ============================================================================
`default_nettype none

interface vfc_cmd_if import vfc_pkg::*;;
    logic      valid;
    logic      ready;
    cmd_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface vfc_face_if import vfc_pkg::*;;
    logic       valid;
    logic       ready;
    face_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/vfc_voxel_ram.sv
// ============================================================================
// vfc_voxel_ram: cell type store
// Simple dual-port memory, one write and one registered read per cycle.
// ============================================================================
`default_nettype none

module vfc_voxel_ram import vfc_pkg::*;
#(
    parameter  int DEPTH  = (X_LEN_DEF + 2) * (Y_LEN_DEF + 2) * (Z_LEN_DEF + 2),
    localparam int ADDR_W = $clog2(DEPTH)
)
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [CELL_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [CELL_W-1:0] rd_data
);

    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> design/voxel_face_culling_core.sv
// ============================================================================
// voxel_face_culling_core: visible face extraction for one voxel chunk
// Loads padded cells into a store and lists the visible faces of a block.
// ============================================================================
// A load word writes one padded cell (0..LEN+1 per axis; out-of-range loads
// are dropped, type 3 is stored as solid) and leaves the core ready for the
// next command word. A query word names an interior block and returns one
// face word per visible face, in the order up, bottom, front, back, left,
// right, with last on the final one; an air block or a fully hidden block
// returns one empty word, an out-of-range coordinate one error word. The
// cell store has a single read port, so a query reads its block and its six
// neighbors one cell per cycle; an air block skips the neighbor reads. The
// user must see that cells are read only after the chunk is loaded; the
// block does not enforce it. Loads and query reads never share a cycle, so
// the store needs no forwarding. The last face word may still wait in the
// output register while the next command word is accepted.
`default_nettype none

module voxel_face_culling_core import vfc_pkg::*;
#(
    parameter int X_LEN = X_LEN_DEF,
    parameter int Y_LEN = Y_LEN_DEF,
    parameter int Z_LEN = Z_LEN_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    vfc_cmd_if.sink   cmd,
    vfc_face_if.source face
);

    // Padded store geometry: address = x + z*PX + y*PX*PZ
    localparam int PX     = X_LEN + 2;
    localparam int PY     = Y_LEN + 2;
    localparam int PZ     = Z_LEN + 2;
    localparam int DEPTH  = PX * PY * PZ;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int STEP_Y = PX * PZ;
    localparam int STEP_Z = PX;
    localparam int STEP_X = 1;
    localparam int CENTER_OFS = STEP_X + STEP_Z + STEP_Y;

    // Face code terms
    localparam int X_Y = X_LEN * Y_LEN;
    localparam int VOL = X_LEN * Y_LEN * Z_LEN;
    localparam logic [CODE_W-1:0] WATER_TERM = CODE_W'(VOL * NUM_DIRS);
    localparam logic [CODE_W-1:0] SOLID_TERM = CODE_W'(VOL * NUM_DIRS * 2);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EMIT,
        S_ERROR
    } state_t;

    state_t                state_reg;
    logic [DIR_W-1:0]      idx_reg;      // index of the cell arriving from the store
    logic [ADDR_W-1:0]     center_reg;   // store address of the queried block
    logic [CELL_W-1:0]     self_reg;
    logic [NUM_DIRS-1:0]   mask_reg;     // visible faces not yet sent
    logic [CODE_W-1:0]     base_reg;     // face code without the direction term
    logic                  out_valid_reg;
    face_word_t            out_data_reg;

    logic                  cmd_fire;
    logic                  out_free;
    logic                  out_load;
    logic [ADDR_W-1:0]     lin_addr;
    logic                  load_ok;
    logic                  query_ok;
    logic [CELL_W-1:0]     load_type;
    logic                  wr_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic [CELL_W-1:0]     rd_data;
    logic                  nb_visible;
    logic [DIR_W-1:0]      pick_dir;
    logic [NUM_DIRS-1:0]   pick_bit;
    logic [CODE_W-1:0]     code_base;

    assign cmd.ready  = (state_reg == S_IDLE);
    assign cmd_fire   = cmd.valid && cmd.ready;
    assign out_free   = !out_valid_reg || face.ready;
    assign face.valid = out_valid_reg;
    assign face.data  = out_data_reg;

    // A new face word enters the output register this cycle
    assign out_load = ((state_reg == S_EMIT) || (state_reg == S_ERROR)) && out_free;

    // Linear address of the raw coordinates; a query adds one on every axis
    assign lin_addr = ADDR_W'(32'(cmd.data.pos_x)
                            + 32'(cmd.data.pos_z) * 32'(STEP_Z)
                            + 32'(cmd.data.pos_y) * 32'(STEP_Y));

    assign load_ok  = (32'(cmd.data.pos_x) < 32'(PX))
                   && (32'(cmd.data.pos_y) < 32'(PY))
                   && (32'(cmd.data.pos_z) < 32'(PZ));
    assign query_ok = (32'(cmd.data.pos_x) < 32'(X_LEN))
                   && (32'(cmd.data.pos_y) < 32'(Y_LEN))
                   && (32'(cmd.data.pos_z) < 32'(Z_LEN));

    assign load_type = (cmd.data.cell_type == CELL_ALT) ? CELL_SOLID : cmd.data.cell_type;
    assign wr_en     = cmd_fire && (cmd.data.op == OP_LOAD) && load_ok;

    assign code_base = CODE_W'(32'(cmd.data.pos_x)
                             + 32'(cmd.data.pos_y) * 32'(X_LEN)
                             + 32'(cmd.data.pos_z) * 32'(X_Y));

    // Read address: the block itself on accept, then its neighbor in
    // direction idx_reg while the previous cell comes back
    always_comb
    begin
        rd_addr = center_reg;
        if (state_reg == S_IDLE)
        begin
            rd_addr = lin_addr + ADDR_W'(CENTER_OFS);
        end
        else
        begin
            unique case (idx_reg)
                DIR_UP:     rd_addr = center_reg + ADDR_W'(STEP_Y);
                DIR_BOTTOM: rd_addr = center_reg - ADDR_W'(STEP_Y);
                DIR_FRONT:  rd_addr = center_reg - ADDR_W'(STEP_Z);
                DIR_BACK:   rd_addr = center_reg + ADDR_W'(STEP_Z);
                DIR_LEFT:   rd_addr = center_reg - ADDR_W'(STEP_X);
                DIR_RIGHT:  rd_addr = center_reg + ADDR_W'(STEP_X);
                default:    rd_addr = center_reg;
            endcase
        end
    end

    // A face shows toward air, and toward water from a non-water block
    assign nb_visible = (rd_data == CELL_AIR)
                     || ((rd_data == CELL_WATER) && (self_reg != CELL_WATER));

    // Lowest pending face goes out first
    always_comb
    begin
        pick_dir = DIR_UP;
        for (int i = NUM_DIRS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                pick_dir = DIR_W'(i);
            end
        end
        pick_bit = NUM_DIRS'(1) << pick_dir;
    end

    vfc_voxel_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (lin_addr),
        .wr_data (load_type),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            mask_reg      <= '0;
            center_reg    <= '0;
            self_reg      <= CELL_AIR;
            base_reg      <= '0;
            out_data_reg  <= '0;
        end
        else
        begin
            // Hold the word until taken, then drop valid unless a new one loads
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (face.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_fire && (cmd.data.op == OP_QUERY))
                    begin
                        center_reg <= lin_addr + ADDR_W'(CENTER_OFS);
                        base_reg   <= code_base;
                        idx_reg    <= '0;
                        mask_reg   <= '0;
                        state_reg  <= query_ok ? S_READ : S_ERROR;
                    end
                end

                S_READ:
                begin
                    if (idx_reg == '0)
                    begin
                        // Block itself: add its type term, stop early on air
                        self_reg <= rd_data;
                        if (rd_data == CELL_WATER)
                        begin
                            base_reg <= base_reg + WATER_TERM;
                        end
                        else if (rd_data != CELL_AIR)
                        begin
                            base_reg <= base_reg + SOLID_TERM;
                        end
                        if (rd_data == CELL_AIR)
                        begin
                            state_reg <= S_EMIT;
                        end
                    end
                    else
                    begin
                        mask_reg <= mask_reg
                                  | (NUM_DIRS'(nb_visible) << (idx_reg - DIR_W'(1)));
                    end
                    idx_reg <= idx_reg + DIR_W'(1);
                    if (idx_reg == DIR_W'(NUM_DIRS))
                    begin
                        state_reg <= S_EMIT;
                    end
                end

                S_EMIT:
                begin
                    if (out_free)
                    begin
                        if (mask_reg == '0)
                        begin
                            out_data_reg <= '{face_code: '0, face_dir: '0,
                                              transparent: 1'b0, face_present: 1'b0,
                                              query_error: 1'b0, last: 1'b1};
                            state_reg    <= S_IDLE;
                        end
                        else
                        begin
                            out_data_reg <= '{
                                face_code:    base_reg
                                            + CODE_W'(32'(pick_dir) * 32'(VOL)),
                                face_dir:     pick_dir,
                                transparent:  (self_reg == CELL_WATER),
                                face_present: 1'b1,
                                query_error:  1'b0,
                                last:         ((mask_reg & ~pick_bit) == '0)};
                            mask_reg     <= mask_reg & ~pick_bit;
                            if ((mask_reg & ~pick_bit) == '0)
                            begin
                                state_reg <= S_IDLE;
                            end
                        end
                    end
                end

                S_ERROR:
                begin
                    if (out_free)
                    begin
                        out_data_reg  <= '{face_code: '0, face_dir: '0,
                                           transparent: 1'b0, face_present: 1'b0,
                                           query_error: 1'b1, last: 1'b1};
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
